@@ hdl/alir_pkg.sv @@
`default_nettype none

package alir_pkg;

    // Default sizes of the list storage.
    localparam int CAPACITY_DEF    = 256;
    localparam int HANDLE_BITS_DEF = 32;

    // Fixed field widths of the ports.
    localparam int OPCODE_W    = 3;
    localparam int POS_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    // Command codes. Code seven is unused and does nothing.
    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_POS   = 3'd1,
        OP_INS_END   = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_POS   = 3'd4,
        OP_REM_END   = 3'd5,
        OP_READ      = 3'd6
    } t_opcode;

    // Status codes of a result.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_EMPTY  = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    // Shift control broadcast to every cell of the row.
    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/array_list_insert_remove.sv @@
// Ordered list of handles held in a row of cells that shift in parallel.
// A result is offered once the command has passed the execute state into the output state.
// A new command is taken only after the previous result has been taken; each command
// passes through the command register, the cell row update and the result register.
// Reset (synchronous, active low) empties the list and drops any pending result.
`default_nettype none

module array_list_insert_remove import alir_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [OPCODE_W-1:0]    i_opcode,
    input  wire logic [POS_W-1:0]       i_position,
    input  wire logic [VALUE_W-1:0]     i_entry_value,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [STATUS_W-1:0]    o_status,
    output logic      [VALUE_W-1:0]     o_returned_value,
    output logic      [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int MW    = (HANDLE_BITS > VALUE_W) ? HANDLE_BITS : VALUE_W;
    localparam int OCW   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    t_state                 r_state;
    t_state                 n_state;
    t_opcode                r_op;
    logic [POS_W-1:0]       r_pos;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    t_status                r_status;
    t_status                n_status;
    logic [HANDLE_BITS-1:0] r_ret;
    logic [HANDLE_BITS-1:0] n_ret;

    logic                   w_in_xfer;
    logic [MW-1:0]          w_in_ext;
    logic [MW-1:0]          w_out_ext;
    logic [OCW-1:0]         w_cnt_ext;
    logic [CW-1:0]          w_at;
    logic [CW-1:0]          w_cnt_x;
    t_cell_ctl              w_ctl;
    logic [HANDLE_BITS-1:0] w_read;

    logic [HANDLE_BITS-1:0] w_value [CAPACITY];
    logic [HANDLE_BITS-1:0] w_sel   [CAPACITY];

    assign w_in_xfer = i_valid && !o_stall;
    assign w_in_ext  = MW'(i_entry_value);
    assign w_cnt_x   = CW'(r_count);

    // Row of cells; each hands its entry to both neighbours.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [HANDLE_BITS-1:0] w_left;
        logic [HANDLE_BITS-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_value[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[k+1];
        end

        alir_cell #(
            .HANDLE_BITS (HANDLE_BITS),
            .CW          (CW),
            .INDEX       (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_at        (w_at),
            .i_handle    (r_handle),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_value     (w_value[k]),
            .o_sel_value (w_sel[k])
        );
    end

    // Only the addressed cell offers its entry, the others offer zero, so an OR gathers it.
    always_comb begin
        w_read = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read = w_read | w_sel[k];
        end
    end

    // Index, checks and cell control for the command under way.
    always_comb begin
        w_at     = CW'(r_pos);
        n_status = STAT_OK;
        w_ctl    = '0;
        unique case (r_op)
            OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
                if (r_op == OP_INS_FRONT) begin
                    w_at = '0;
                end else if (r_op == OP_INS_END) begin
                    w_at = w_cnt_x;
                end
                if (r_count == FULL_COUNT) begin
                    n_status = STAT_FULL;
                end else if (w_at > w_cnt_x) begin
                    n_status = STAT_BADPOS;
                end else begin
                    w_ctl.do_ins = (r_state == ST_EXEC);
                end
            end
            OP_REM_FRONT, OP_REM_POS, OP_REM_END, OP_READ: begin
                if (r_op == OP_REM_FRONT) begin
                    w_at = '0;
                end else if (r_op == OP_REM_END) begin
                    w_at = w_cnt_x - CW'(1);
                end
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else if (w_at >= w_cnt_x) begin
                    n_status = STAT_BADPOS;
                end else if (r_op != OP_READ) begin
                    w_ctl.do_rem = (r_state == ST_EXEC);
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    // Returned handle and new count follow from the checks above.
    always_comb begin
        n_ret   = '0;
        n_count = r_count;
        if (n_status == STAT_OK) begin
            if (r_op == OP_REM_FRONT || r_op == OP_REM_POS || r_op == OP_REM_END
                || r_op == OP_READ) begin
                n_ret = w_read;
            end
        end
        if (w_ctl.do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Sequencer: take a command, update the row, then hold the result.
    always_comb begin
        n_state = r_state;
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) begin
                r_count <= n_count;
            end
        end
    end

    // Command and result registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op     <= t_opcode'(i_opcode);
            r_pos    <= i_position;
            r_handle <= w_in_ext[HANDLE_BITS-1:0];
        end
        if (r_state == ST_EXEC) begin
            r_status <= n_status;
            r_ret    <= n_ret;
        end
    end

    assign w_out_ext        = MW'(r_ret);
    assign w_cnt_ext        = OCW'(r_count);
    assign o_status         = r_status;
    assign o_returned_value = w_out_ext[VALUE_W-1:0];
    assign o_entry_count    = w_cnt_ext[COUNT_OUT_W-1:0];

    // The count never exceeds the number of cells.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    // A full report comes only from a full list.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == STAT_FULL) |-> (r_count == FULL_COUNT))
        else $error("full status with room left");

    // An empty report comes only from an empty list.
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == STAT_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries present");

    // An accepted command always yields a result, after the execute state.
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> ##1 o_valid)
        else $error("result missing after command transfer");

endmodule

`default_nettype wire

@@ hdl/alir_cell.sv @@
`default_nettype none

module alir_cell import alir_pkg::*; #(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int CW          = 9,
    parameter int INDEX       = 0
) (
    input  wire logic                   i_clk,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [CW-1:0]          i_at,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    input  wire logic [HANDLE_BITS-1:0] i_left,
    input  wire logic [HANDLE_BITS-1:0] i_right,
    output logic      [HANDLE_BITS-1:0] o_value,
    output logic      [HANDLE_BITS-1:0] o_sel_value
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [HANDLE_BITS-1:0] r_value;
    logic [HANDLE_BITS-1:0] n_value;
    logic                   w_is_at;
    logic                   w_above;

    // Position of this cell relative to the command's index.
    assign w_is_at = (i_at == MY_INDEX);
    assign w_above = (MY_INDEX > i_at);

    // An insert moves the entry up from the left neighbour and drops the new
    // handle at the gap; a remove pulls the entry down from the right.
    always_comb begin
        n_value = r_value;
        if (i_ctl.do_ins && w_above) begin
            n_value = i_left;
        end else if (i_ctl.do_ins && w_is_at) begin
            n_value = i_handle;
        end else if (i_ctl.do_rem && (w_above || w_is_at)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // The addressed cell offers its old entry for a read or a remove.
    assign o_value     = r_value;
    assign o_sel_value = w_is_at ? r_value : '0;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import alir_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 6;
    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int RANDOM_CMDS = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYC   = 10;
    localparam int QUIET_FROM  = 400;
    localparam int QUIET_TO    = 900;

    // Code seven is not a member of the command enum; it must act as a no-op.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
    } t_command;

    typedef struct packed {
        t_status                status;
        logic [VALUE_W-1:0]     value;
        logic [COUNT_OUT_W-1:0] count;
    } t_reply;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [OPCODE_W-1:0]    i_opcode;
    logic [POS_W-1:0]       i_position;
    logic [VALUE_W-1:0]     i_entry_value;
    logic                   o_valid;
    logic                   i_stall;
    logic [STATUS_W-1:0]    o_status;
    logic [VALUE_W-1:0]     o_returned_value;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    t_command           cmd_queue[$];
    t_reply             awaited_replies[$];
    logic [VALUE_W-1:0] shadow_list[LIST_CAP];
    int                 shadow_count;
    int                 n_accepted;
    int                 n_total;
    int                 n_errors;
    int                 cyc;

    array_list_insert_remove u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_position       (i_position),
        .i_entry_value    (i_entry_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_returned_value (o_returned_value),
        .o_entry_count    (o_entry_count)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Cycle counter and the overall timeout.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random idle decision shared by both sides, suppressed during a quiet window.
    function automatic logic idle_now();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 25;
    endfunction

    // Applies one command to the shadow list and records the reply it should give.
    task automatic apply_command(input logic [OPCODE_W-1:0] op,
                                 input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] val);
        t_reply r;
        int     at;
        int     i;
        r.status = STAT_OK;
        r.value  = '0;
        case (op)
            OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
                at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? shadow_count : int'(pos);
                if (shadow_count >= LIST_CAP) begin
                    r.status = STAT_FULL;
                end else if (at > shadow_count) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (i = shadow_count; i > at; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[at] = val;
                    shadow_count++;
                end
            end
            OP_REM_FRONT, OP_REM_POS, OP_REM_END, OP_READ: begin
                at = (op == OP_REM_FRONT) ? 0 : (op == OP_REM_END) ? shadow_count - 1 : int'(pos);
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (at >= shadow_count) begin
                    r.status = STAT_BADPOS;
                end else if (op == OP_READ) begin
                    r.value = shadow_list[at];
                end else begin
                    r.value = shadow_list[at];
                    shadow_count--;
                    for (i = at; i < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                end
            end
            default: begin
            end
        endcase
        r.count = shadow_count[COUNT_OUT_W-1:0];
        awaited_replies.push_back(r);
    endtask

    // Number of entries after a command; used only to steer the generator.
    function automatic int count_after(input logic [OPCODE_W-1:0] op,
                                       input logic [POS_W-1:0] pos, input int c);
        int at;
        case (op)
            OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
                at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? c : int'(pos);
                if (c < LIST_CAP && at <= c)
                    return c + 1;
            end
            OP_REM_FRONT, OP_REM_POS, OP_REM_END: begin
                at = (op == OP_REM_FRONT) ? 0 : (op == OP_REM_END) ? c - 1 : int'(pos);
                if (c != 0 && at < c)
                    return c - 1;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
        t_command c;
        c.op  = op;
        c.pos = pos;
        c.val = val;
        cmd_queue.push_back(c);
    endtask

    // Command driver: presents the next pending command and predicts each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_command(i_opcode, i_position, i_entry_value);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (cmd_queue.size() != 0 && !idle_now()) begin
                    i_valid       <= 1'b1;
                    i_opcode      <= cmd_queue[0].op;
                    i_position    <= cmd_queue[0].pos;
                    i_entry_value <= cmd_queue[0].val;
                    cmd_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_reply r;
        int     bad;
        bad = 0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, actual status %0d value %h count %0d",
                             $time, o_status, o_returned_value, o_entry_count);
                    bad = bad + 1;
                end else begin
                    r = awaited_replies.pop_front();
                    if (o_status !== r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, r.status, o_status);
                        bad = bad + 1;
                    end
                    if (o_returned_value !== r.value) begin
                        $display("%0t: returned value expected %h actual %h",
                                 $time, r.value, o_returned_value);
                        bad = bad + 1;
                    end
                    if (o_entry_count !== r.count) begin
                        $display("%0t: entry count expected %0d actual %0d",
                                 $time, r.count, o_entry_count);
                        bad = bad + 1;
                    end
                end
                n_errors <= n_errors + bad;
            end
            i_stall <= idle_now();
        end
    end

    // Stimulus generation, reset and end of run.
    initial begin
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        int                  gen_count;
        int                  roll;
        int                  top;
        logic                filling;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_opcode      = '0;
        i_position    = '0;
        i_entry_value = '0;
        shadow_count  = 0;
        n_accepted    = 0;
        n_errors      = 0;
        cyc           = 0;

        // Directed commands: empty list, bad positions, inserts and appends, reads, removes, the no-op code.
        push_cmd(OP_READ,      8'd0,   32'h0);
        push_cmd(OP_REM_FRONT, 8'd0,   32'h0);
        push_cmd(OP_REM_END,   8'd0,   32'h0);
        push_cmd(OP_REM_POS,   8'd0,   32'h0);
        push_cmd(OP_INS_POS,   8'd1,   32'h1234_5678);
        push_cmd(OP_INS_FRONT, 8'd0,   32'hFFFF_FFFF);
        push_cmd(OP_INS_END,   8'd255, 32'h0000_0000);
        push_cmd(OP_INS_POS,   8'd2,   32'hA5A5_A5A5);
        push_cmd(OP_INS_POS,   8'd1,   32'h5A5A_5A5A);
        push_cmd(OP_READ,      8'd3,   32'h0);
        push_cmd(OP_READ,      8'd4,   32'h0);
        push_cmd(OP_READ,      8'd255, 32'h0);
        push_cmd(OP_INS_POS,   8'd255, 32'hDEAD_BEEF);
        push_cmd(OP_UNUSED,    8'd255, 32'hFFFF_FFFF);
        push_cmd(OP_REM_POS,   8'd4,   32'h0);
        push_cmd(OP_REM_POS,   8'd1,   32'h0);
        push_cmd(OP_REM_END,   8'd0,   32'h0);
        push_cmd(OP_REM_FRONT, 8'd0,   32'h0);
        push_cmd(OP_READ,      8'd0,   32'h0);
        push_cmd(OP_REM_END,   8'd0,   32'h0);
        push_cmd(OP_READ,      8'd0,   32'h0);

        // Random part: fill the list to capacity, linger at full, then drain it.
        gen_count = 0;
        filling   = 1'b1;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            roll = $urandom_range(0, 99);
            if (filling) begin
                if (roll < 75)      op = OPCODE_W'($urandom_range(OP_INS_FRONT, OP_INS_END));
                else if (roll < 88) op = OP_READ;
                else if (roll < 95) op = OPCODE_W'($urandom_range(OP_REM_FRONT, OP_REM_END));
                else                op = OP_UNUSED;
            end else begin
                if (roll < 75)      op = OPCODE_W'($urandom_range(OP_REM_FRONT, OP_REM_END));
                else if (roll < 88) op = OP_READ;
                else if (roll < 95) op = OPCODE_W'($urandom_range(OP_INS_FRONT, OP_INS_END));
                else                op = OP_UNUSED;
            end
            // Mostly legal positions, with a share of arbitrary ones.
            if (op inside {OP_INS_FRONT, OP_INS_POS, OP_INS_END})
                top = (gen_count > 255) ? 255 : gen_count;
            else
                top = (gen_count > 256) ? 255 : gen_count - 1;
            if ($urandom_range(0, 99) < 12 || top < 0)
                pos = POS_W'($urandom_range(0, 255));
            else
                pos = POS_W'($urandom_range(0, top));
            push_cmd(op, pos, $urandom());
            gen_count = count_after(op, pos, gen_count);
            if (filling && gen_count == LIST_CAP && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && gen_count == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
        end
        n_total = cmd_queue.size();

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (n_errors == 0 && awaited_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ array_list_insert_remove.f @@
hdl/alir_pkg.sv
hdl/alir_cell.sv
hdl/array_list_insert_remove.sv
test/tb.sv
